@@ rtl/buddy_page_allocator_assert.svh @@
// Assertion macros for the buddy page allocator.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define BPA_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("buddy page allocator check failed");
`define BPA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("buddy page allocator check failed");
`else
`define BPA_ASSERT_IMP(lbl, ante, cons)
`define BPA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/bpa_pkg.sv @@
package bpa_pkg;

   localparam int POOL_LOG2  = 10;
   localparam int PAGE_SHIFT = 12;
   localparam int POOL_PAGES = 1 << POOL_LOG2;
   localparam int ROW_LOG2   = 5;
   localparam int ROW_BITS   = 1 << ROW_LOG2;
   localparam int MAP_ROWS   = 68;
   localparam int ROW_AW     = 7;
   localparam int ORD_W      = 4;
   localparam int BLK_W      = POOL_LOG2;
   localparam int CNT_W      = POOL_LOG2 + 1;
   localparam int BMEM_W     = ORD_W + 1;

   localparam logic       KIND_ALLOC   = 1'b0;
   localparam logic       KIND_FREE    = 1'b1;
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_NOSPACE = 2'd1;
   localparam logic [1:0] STAT_UNALLOC = 2'd2;
   localparam logic [1:0] STAT_RANGE   = 2'd3;

   // number of free-map rows that hold the nodes of one order
   function automatic logic [ROW_AW-1:0] row_count(input logic [ORD_W-1:0] o);
      logic [ROW_AW-1:0] n;
      if (o <= ORD_W'(POOL_LOG2 - ROW_LOG2)) begin
         n = ROW_AW'(1) << (ORD_W'(POOL_LOG2 - ROW_LOG2) - o);
      end else begin
         n = ROW_AW'(1);
      end
      return n;
   endfunction

   function automatic logic [ROW_AW-1:0] row_base(input logic [ORD_W-1:0] o);
      logic [ROW_AW-1:0] acc;
      acc = '0;
      for (int k = 0; k < POOL_LOG2; k++) begin
         if (ORD_W'(k) < o) begin
            acc = acc + row_count(ORD_W'(k));
         end
      end
      return acc;
   endfunction

   function automatic logic [ROW_AW-1:0] map_row(input logic [ORD_W-1:0] o,
                                                 input logic [BLK_W-1:0] blk);
      return row_base(o) + ROW_AW'(blk >> ROW_LOG2);
   endfunction

   // bits of a row that carry nodes of the given order
   function automatic logic [ROW_BITS-1:0] row_mask(input logic [ORD_W-1:0] o);
      logic [ROW_BITS-1:0] m;
      logic [CNT_W-1:0]    n;
      n = CNT_W'(1) << (ORD_W'(POOL_LOG2) - o);
      for (int i = 0; i < ROW_BITS; i++) begin
         m[i] = (CNT_W'(i) < n);
      end
      return m;
   endfunction

endpackage

@@ rtl/buddy_page_allocator.sv @@
// Binary buddy allocator over a pool of 1024 pages of 4 KiB starting at page
// csr_pool_base_page. After reset the block runs a clearing pass over its
// memories with req_stall high. An allocate beat scans the free map (one
// free-map row of 32 nodes is read per scan step, at most 32 rows for order 0)
// and then splits down to the wanted order; it ends early when no block is
// large enough. A free beat merges with free buddies and ends early when the
// page is not an allocated block start or lies outside the pool. Every scan,
// split and merge step waits for the registered read of the free-map memory.
// One item is worked on at a time; the next beat is taken while a finished
// result still waits in the output register.
module buddy_page_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [31:0] req_request_bytes,
   input  logic [31:0] req_release_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_granted_address,
   output logic [3:0]  rsp_granted_order,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [19:0] csr_pool_base_page
);

   `include "buddy_page_allocator_assert.svh"

   localparam int OW = bpa_pkg::ORD_W;
   localparam int BW = bpa_pkg::BLK_W;
   localparam int RW = bpa_pkg::ROW_AW;
   localparam int RB = bpa_pkg::ROW_BITS;
   localparam int CW = bpa_pkg::CNT_W;

   typedef enum logic [13:0] {
      ST_CLEAR     = 14'b00000000000001,
      ST_IDLE      = 14'b00000000000010,
      ST_SIZE      = 14'b00000000000100,
      ST_PICK      = 14'b00000000001000,
      ST_SCAN_RD   = 14'b00000000010000,
      ST_SCAN_CHK  = 14'b00000000100000,
      ST_SPLIT_RD  = 14'b00000001000000,
      ST_SPLIT_CHK = 14'b00000010000000,
      ST_MARK      = 14'b00000100000000,
      ST_FREE_RD   = 14'b00001000000000,
      ST_FREE_CHK  = 14'b00010000000000,
      ST_MERGE_RD  = 14'b00100000000000,
      ST_MERGE_CHK = 14'b01000000000000,
      ST_DONE      = 14'b10000000000000
   } state_type;

   state_type         state_ff, state_in;
   logic [19:0]       base_ff, base_in;
   logic [31:0]       bytes_ff, bytes_in;
   logic [19:0]       page_abs_ff, page_abs_in;
   logic [BW-1:0]     page_ff, page_in;
   logic [4:0]        want_ff, want_in;
   logic [OW-1:0]     ord_ff, ord_in;
   logic [OW-1:0]     orig_ff, orig_in;
   logic [BW-1:0]     blk_ff, blk_in;
   logic [RW-1:0]     row_ff, row_in;
   logic [BW-1:0]     clr_ff, clr_in;
   logic [CW-1:0]     cnt_ff [bpa_pkg::POOL_LOG2+1];
   logic [CW-1:0]     cnt_in [bpa_pkg::POOL_LOG2+1];
   logic [31:0]       res_addr_ff, res_addr_in;
   logic [OW-1:0]     res_ord_ff, res_ord_in;
   logic [1:0]        res_stat_ff, res_stat_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_addr_ff, rsp_addr_in;
   logic [OW-1:0]     rsp_ord_ff, rsp_ord_in;
   logic [1:0]        rsp_stat_ff, rsp_stat_in;

   // free-map memory port
   logic              map_we;
   logic [RW-1:0]     map_waddr, map_raddr;
   logic [RB-1:0]     map_wdata, map_rdata;
   // block-start memory port: {used, order}
   logic              bm_we;
   logic [BW-1:0]     bm_waddr, bm_raddr;
   logic [bpa_pkg::BMEM_W-1:0] bm_wdata, bm_rdata;

   // scan helpers
   logic [RB-1:0]     masked;
   logic [4:0]        low_idx;
   logic [RW-1:0]     scan_last;
   logic              rsp_load;
   logic [20:0]       pages;
   logic [20:0]       pages_m1;
   logic [4:0]        want_calc;
   logic [19:0]       rel;
   logic [BW-1:0]     buddy;
   logic [OW-1:0]     pick_ord;
   logic              pick_hit;
   logic [BW-1:0]     grant_page;

   bpa_ram #(.WIDTH(RB), .DEPTH(bpa_pkg::MAP_ROWS)) u_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   bpa_ram #(.WIDTH(bpa_pkg::BMEM_W), .DEPTH(bpa_pkg::POOL_PAGES)) u_blk (
      .clock   (clock),
      .wr_en   (bm_we),
      .wr_addr (bm_waddr),
      .wr_data (bm_wdata),
      .rd_addr (bm_raddr),
      .rd_data (bm_rdata)
   );

   assign masked    = map_rdata & bpa_pkg::row_mask(ord_ff);
   assign scan_last = bpa_pkg::row_base(ord_ff) + bpa_pkg::row_count(ord_ff) - RW'(1);
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign rel       = page_abs_ff - base_ff;
   assign buddy     = blk_ff ^ BW'(1);
   assign grant_page = blk_ff << want_ff[OW-1:0];

   // lowest set node in the row
   always_comb begin
      low_idx = '0;
      for (int i = RB - 1; i >= 0; i--) begin
         if (masked[i]) begin
            low_idx = 5'(i);
         end
      end
   end

   // round the byte count up to pages and then to a power-of-two order
   always_comb begin
      pages     = 21'((33'(bytes_ff) + 33'((1 << bpa_pkg::PAGE_SHIFT) - 1))
                      >> bpa_pkg::PAGE_SHIFT);
      pages_m1  = (pages == '0) ? '0 : pages - 21'(1);
      want_calc = '0;
      for (int i = 0; i < 21; i++) begin
         if (pages_m1[i]) begin
            want_calc = 5'(i + 1);
         end
      end
   end

   // smallest order at or above the wanted one that has a free block
   always_comb begin
      pick_ord = '0;
      pick_hit = 1'b0;
      for (int o = bpa_pkg::POOL_LOG2; o >= 0; o--) begin
         if ((5'(o) >= want_ff) && (cnt_ff[o] != '0)) begin
            pick_ord = OW'(o);
            pick_hit = 1'b1;
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      base_in     = base_ff;
      bytes_in    = bytes_ff;
      page_abs_in = page_abs_ff;
      page_in     = page_ff;
      want_in     = want_ff;
      ord_in      = ord_ff;
      orig_in     = orig_ff;
      blk_in      = blk_ff;
      row_in      = row_ff;
      clr_in      = clr_ff;
      cnt_in      = cnt_ff;
      res_addr_in = res_addr_ff;
      res_ord_in  = res_ord_ff;
      res_stat_in = res_stat_ff;
      map_we      = 1'b0;
      map_waddr   = row_ff;
      map_wdata   = map_rdata;
      map_raddr   = row_ff;
      bm_we       = 1'b0;
      bm_waddr    = page_ff;
      bm_wdata    = bm_rdata;
      bm_raddr    = page_ff;

      if (csr_valid) begin
         base_in = csr_pool_base_page;
      end

      case (state_ff)
         ST_CLEAR: begin
            // wipe both memories; only the whole-pool node starts free
            bm_we    = 1'b1;
            bm_waddr = clr_ff;
            bm_wdata = '0;
            map_we    = (clr_ff < BW'(bpa_pkg::MAP_ROWS));
            map_waddr = clr_ff[RW-1:0];
            map_wdata = (clr_ff[RW-1:0] == bpa_pkg::row_base(OW'(bpa_pkg::POOL_LOG2)))
                        ? RB'(1) : '0;
            clr_in = clr_ff + BW'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               bytes_in    = req_request_bytes;
               page_abs_in = req_release_address[31:bpa_pkg::PAGE_SHIFT];
               state_in    = (req_kind == bpa_pkg::KIND_FREE) ? ST_FREE_RD : ST_SIZE;
            end
         end
         ST_SIZE: begin
            want_in  = want_calc;
            state_in = ST_PICK;
         end
         ST_PICK: begin
            if (want_ff > 5'(bpa_pkg::POOL_LOG2) || !pick_hit) begin
               res_addr_in = '0;
               res_ord_in  = '0;
               res_stat_in = bpa_pkg::STAT_NOSPACE;
               state_in    = ST_DONE;
            end else begin
               ord_in   = pick_ord;
               row_in   = bpa_pkg::row_base(pick_ord);
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            map_raddr = row_ff;
            state_in  = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (masked != '0) begin
               // take the block: drop its free bit
               blk_in    = BW'({5'(row_ff - bpa_pkg::row_base(ord_ff)), low_idx});
               map_we    = 1'b1;
               map_waddr = row_ff;
               map_wdata = map_rdata & ~(RB'(1) << low_idx);
               cnt_in[ord_ff] = cnt_ff[ord_ff] - CW'(1);
               state_in  = (5'(ord_ff) > want_ff) ? ST_SPLIT_RD : ST_MARK;
            end else begin
               row_in   = row_ff + RW'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_SPLIT_RD: begin
            // step down one order, keep the lower half
            ord_in    = ord_ff - OW'(1);
            blk_in    = blk_ff << 1;
            map_raddr = bpa_pkg::map_row(ord_ff - OW'(1), (blk_ff << 1) | BW'(1));
            state_in  = ST_SPLIT_CHK;
         end
         ST_SPLIT_CHK: begin
            // free the upper half
            map_we    = 1'b1;
            map_waddr = bpa_pkg::map_row(ord_ff, buddy);
            map_wdata = map_rdata | (RB'(1) << buddy[4:0]);
            cnt_in[ord_ff] = cnt_ff[ord_ff] + CW'(1);
            state_in  = (5'(ord_ff) > want_ff) ? ST_SPLIT_RD : ST_MARK;
         end
         ST_MARK: begin
            bm_we       = 1'b1;
            bm_waddr    = grant_page;
            bm_wdata    = {1'b1, want_ff[OW-1:0]};
            res_addr_in = {base_ff + 20'(grant_page), {bpa_pkg::PAGE_SHIFT{1'b0}}};
            res_ord_in  = want_ff[OW-1:0];
            res_stat_in = bpa_pkg::STAT_OK;
            state_in    = ST_DONE;
         end
         ST_FREE_RD: begin
            if (page_abs_ff < base_ff || rel[19:BW] != '0) begin
               res_addr_in = '0;
               res_ord_in  = '0;
               res_stat_in = bpa_pkg::STAT_RANGE;
               state_in    = ST_DONE;
            end else begin
               page_in  = rel[BW-1:0];
               bm_raddr = rel[BW-1:0];
               state_in = ST_FREE_CHK;
            end
         end
         ST_FREE_CHK: begin
            res_addr_in = '0;
            if (!bm_rdata[OW]) begin
               res_ord_in  = '0;
               res_stat_in = bpa_pkg::STAT_UNALLOC;
               state_in    = ST_DONE;
            end else begin
               bm_we    = 1'b1;
               bm_waddr = page_ff;
               bm_wdata = {1'b0, bm_rdata[OW-1:0]};
               if (bm_rdata[OW-1:0] > OW'(bpa_pkg::POOL_LOG2)) begin
                  orig_in = OW'(bpa_pkg::POOL_LOG2);
                  ord_in  = OW'(bpa_pkg::POOL_LOG2);
                  blk_in  = '0;
               end else begin
                  orig_in = bm_rdata[OW-1:0];
                  ord_in  = bm_rdata[OW-1:0];
                  blk_in  = page_ff >> bm_rdata[OW-1:0];
               end
               state_in = ST_MERGE_RD;
            end
         end
         ST_MERGE_RD: begin
            // block and buddy share one row
            map_raddr = bpa_pkg::map_row(ord_ff, blk_ff);
            state_in  = ST_MERGE_CHK;
         end
         ST_MERGE_CHK: begin
            map_we    = 1'b1;
            map_waddr = bpa_pkg::map_row(ord_ff, blk_ff);
            if (ord_ff < OW'(bpa_pkg::POOL_LOG2) && map_rdata[buddy[4:0]]) begin
               // absorb the buddy and climb
               map_wdata = map_rdata & ~(RB'(1) << buddy[4:0]);
               cnt_in[ord_ff] = cnt_ff[ord_ff] - CW'(1);
               blk_in   = blk_ff >> 1;
               ord_in   = ord_ff + OW'(1);
               state_in = ST_MERGE_RD;
            end else begin
               map_wdata = map_rdata | (RB'(1) << blk_ff[4:0]);
               cnt_in[ord_ff] = cnt_ff[ord_ff] + CW'(1);
               res_ord_in  = orig_ff;
               res_stat_in = bpa_pkg::STAT_OK;
               state_in    = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register: hold while stalled, load on finish
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_addr_in  = rsp_addr_ff;
      rsp_ord_in   = rsp_ord_ff;
      rsp_stat_in  = rsp_stat_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_addr_in  = res_addr_ff;
         rsp_ord_in   = res_ord_ff;
         rsp_stat_in  = res_stat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int o = 0; o <= bpa_pkg::POOL_LOG2; o++) begin
            cnt_ff[o] <= (o == bpa_pkg::POOL_LOG2) ? CW'(1) : '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
      bytes_ff    <= bytes_in;
      page_abs_ff <= page_abs_in;
      page_ff     <= page_in;
      want_ff     <= want_in;
      ord_ff      <= ord_in;
      orig_ff     <= orig_in;
      blk_ff      <= blk_in;
      row_ff      <= row_in;
      res_addr_ff <= res_addr_in;
      res_ord_ff  <= res_ord_in;
      res_stat_ff <= res_stat_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_ord_ff  <= rsp_ord_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_address = rsp_addr_ff;
   assign rsp_granted_order   = rsp_ord_ff;
   assign rsp_status          = rsp_stat_ff;

   // the free count promised a hit, so the scan never runs past its order
   `BPA_ASSERT_IMP(a_scan_bounded, (state_ff == ST_SCAN_CHK) && (masked == '0), row_ff != scan_last)
   `BPA_ASSERT_IMP(a_split_above, state_ff == ST_SPLIT_RD, 5'(ord_ff) > want_ff)
   `BPA_ASSERT_IMP(a_merge_bound, state_ff == ST_MERGE_RD, ord_ff <= OW'(bpa_pkg::POOL_LOG2))
   `BPA_ASSERT_NEXT(a_done_loads, rsp_load, rsp_valid_ff && (state_ff == ST_IDLE))

endmodule

@@ rtl/bpa_ram.sv @@
module bpa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
